// ===== sv/dlh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dlh_pkg;

  localparam int unsigned BKT_W = 5;

  // result codes
  localparam logic [2:0] OUT_NOT_DNS   = 3'd0;
  localparam logic [2:0] OUT_STORED    = 3'd1;
  localparam logic [2:0] OUT_DROPPED   = 3'd2;
  localparam logic [2:0] OUT_COUNTED   = 3'd3;
  localparam logic [2:0] OUT_OVER      = 3'd4;
  localparam logic [2:0] OUT_UNMATCHED = 3'd5;
  localparam logic [2:0] OUT_READ      = 3'd6;

  // register indexes
  localparam logic CFG_MAX_RTT      = 1'b0;
  localparam logic CFG_SERVICE_PORT = 1'b1;

  localparam logic [63:0] MAX_RTT_RESET      = 64'd500000000;
  localparam logic [15:0] SERVICE_PORT_RESET = 16'd53;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_IPV6  = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  typedef struct packed {
    logic        operation;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [63:0] arrival_time_ns;
    logic [4:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [4:0]  bucket;
    logic [63:0] bucket_count;
    logic        over_ipv6;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic        is_ipv6;
    logic [15:0] id;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] time_ns;
  } entry_t;

  typedef struct packed {
    logic       parse_en;
    logic       latch_job;
    logic       clr_step;
    logic       scan_start;
    logic       scan_chk;
    logic       decide;
    logic       log_init;
    logic       log_step;
    logic       hist_rd_log;
    logic       hist_inc;
    logic       read_latch;
    logic       out_ld;
    logic [2:0] out_code;
  } dlh_cmd_t;

  typedef struct packed {
    logic op;
    logic last;
    logic dns_ok;
    logic job_resp;
    logic cnt_last;
    logic hit;
    logic free;
    logic in_limit;
    logic log_done;
  } dlh_status_t;

endpackage

`default_nettype wire

// ===== sv/dlh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/dlh_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlh_datapath #(
  parameter int unsigned TableEntries     = 1024,
  parameter int unsigned HistogramBuckets = 30
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dlh_pkg::in_word_t   in_word_i,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [63:0]         cfg_data_i,
  input  wire dlh_pkg::dlh_cmd_t   cmd_i,
  output dlh_pkg::dlh_status_t     status_o,
  output dlh_pkg::out_word_t       out_word_o
);
  import dlh_pkg::*;

  localparam int unsigned TW = $clog2(TableEntries);
  localparam int unsigned BW = $clog2(HistogramBuckets);
  localparam int unsigned IW = (BW > BKT_W) ? BW : BKT_W;

  // configuration
  logic [63:0] max_rtt_q;
  logic [15:0] svc_port_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rtt_q  <= MAX_RTT_RESET;
      svc_port_q <= SERVICE_PORT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_RTT:      max_rtt_q  <= cfg_data_i;
        CFG_SERVICE_PORT: svc_port_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // byte parser
  logic [6:0]  pos_q;
  logic [15:0] kind_q, kind_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d, qid_q, qid_d;
  logic        resp_q, resp_d;
  logic [63:0] shi_q, shi_d, slo_q, slo_d, dhi_q, dhi_d, dlo_q, dlo_d;
  logic [7:0]  b;
  logic [7:0]  len;
  logic        is_v4, is_v6, over6, dns_ok;

  assign b = in_word_i.frame_byte;

  always_comb begin
    kind_d  = kind_q;
    proto_d = proto_q;
    sport_d = sport_q;
    dport_d = dport_q;
    qid_d   = qid_q;
    resp_d  = resp_q;
    shi_d   = shi_q;
    slo_d   = slo_q;
    dhi_d   = dhi_q;
    dlo_d   = dlo_q;
    if (pos_q == 7'd12 || pos_q == 7'd13) begin
      kind_d = {kind_q[7:0], b};
    end else if (kind_q == ETH_IPV4) begin
      if (pos_q == 7'd23) proto_d = b;
      else if (pos_q >= 7'd26 && pos_q <= 7'd29) slo_d = {slo_q[55:0], b};
      else if (pos_q >= 7'd30 && pos_q <= 7'd33) dlo_d = {dlo_q[55:0], b};
      else if (pos_q == 7'd34 || pos_q == 7'd35) sport_d = {sport_q[7:0], b};
      else if (pos_q == 7'd36 || pos_q == 7'd37) dport_d = {dport_q[7:0], b};
      else if (pos_q == 7'd42 || pos_q == 7'd43) qid_d = {qid_q[7:0], b};
      else if (pos_q == 7'd44) resp_d = b[7];
    end else if (kind_q == ETH_IPV6) begin
      if (pos_q == 7'd20) proto_d = b;
      else if (pos_q >= 7'd22 && pos_q <= 7'd29) shi_d = {shi_q[55:0], b};
      else if (pos_q >= 7'd30 && pos_q <= 7'd37) slo_d = {slo_q[55:0], b};
      else if (pos_q >= 7'd38 && pos_q <= 7'd45) dhi_d = {dhi_q[55:0], b};
      else if (pos_q >= 7'd46 && pos_q <= 7'd53) dlo_d = {dlo_q[55:0], b};
      else if (pos_q == 7'd54 || pos_q == 7'd55) sport_d = {sport_q[7:0], b};
      else if (pos_q == 7'd56 || pos_q == 7'd57) dport_d = {dport_q[7:0], b};
      else if (pos_q == 7'd62 || pos_q == 7'd63) qid_d = {qid_q[7:0], b};
      else if (pos_q == 7'd64) resp_d = b[7];
    end
  end

  assign len    = {1'b0, pos_q} + 8'd1;
  assign is_v4  = (kind_d == ETH_IPV4) && (len >= 8'd54);
  assign is_v6  = (kind_d == ETH_IPV6) && (len >= 8'd74);
  assign over6  = (kind_d == ETH_IPV6) && (len >= 8'd14);
  assign dns_ok = (is_v4 || is_v6) && (proto_d == PROTO_UDP) &&
                  (sport_d == svc_port_q || dport_d == svc_port_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      kind_q  <= '0;
      proto_q <= '0;
      sport_q <= '0;
      dport_q <= '0;
      qid_q   <= '0;
      resp_q  <= 1'b0;
      shi_q   <= '0;
      slo_q   <= '0;
      dhi_q   <= '0;
      dlo_q   <= '0;
    end else if (cmd_i.parse_en) begin
      if (in_word_i.frame_end) begin
        pos_q   <= '0;
        kind_q  <= '0;
        proto_q <= '0;
        sport_q <= '0;
        dport_q <= '0;
        qid_q   <= '0;
        resp_q  <= 1'b0;
        shi_q   <= '0;
        slo_q   <= '0;
        dhi_q   <= '0;
        dlo_q   <= '0;
      end else begin
        if (pos_q != 7'd127) pos_q <= pos_q + 7'd1;
        kind_q  <= kind_d;
        proto_q <= proto_d;
        sport_q <= sport_d;
        dport_q <= dport_d;
        qid_q   <= qid_d;
        resp_q  <= resp_d;
        shi_q   <= shi_d;
        slo_q   <= slo_d;
        dhi_q   <= dhi_d;
        dlo_q   <= dlo_d;
      end
    end
  end

  // frame under judgment
  logic        job_v6_q, job_over6_q, job_resp_q;
  logic [15:0] job_id_q;
  logic [63:0] job_hi_q, job_lo_q, job_now_q;
  logic [4:0]  ridx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_job) begin
      job_v6_q    <= is_v6;
      job_over6_q <= over6;
      job_resp_q  <= resp_d;
      job_id_q    <= qid_d;
      job_hi_q    <= resp_d ? dhi_d : shi_d;
      job_lo_q    <= resp_d ? dlo_d : slo_d;
      job_now_q   <= in_word_i.arrival_time_ns;
    end
    if (cmd_i.read_latch) begin
      ridx_q <= in_word_i.read_index;
    end
  end

  // key table
  logic [TW-1:0] cnt_q, hit_idx_q, free_idx_q;
  logic          hit_q, free_q;
  logic [63:0]   hit_time_q, delta_q;
  entry_t        tbl_rdata, tbl_wdata;
  logic          tbl_we;
  logic [TW-1:0] tbl_waddr;
  logic          ent_match;

  assign ent_match = tbl_rdata.valid && (tbl_rdata.is_ipv6 == job_v6_q) &&
                     (tbl_rdata.id == job_id_q) && (tbl_rdata.addr_hi == job_hi_q) &&
                     (tbl_rdata.addr_lo == job_lo_q);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = cnt_q;
    tbl_wdata = '0;
    if (cmd_i.clr_step) begin
      tbl_we = 1'b1;
    end else if (cmd_i.decide) begin
      if (job_resp_q) begin
        tbl_we    = hit_q;
        tbl_waddr = hit_idx_q;
      end else begin
        tbl_we          = hit_q || free_q;
        tbl_waddr       = hit_q ? hit_idx_q : free_idx_q;
        tbl_wdata.valid = 1'b1;
      end
      tbl_wdata.is_ipv6 = job_v6_q;
      tbl_wdata.id      = job_id_q;
      tbl_wdata.addr_hi = job_hi_q;
      tbl_wdata.addr_lo = job_lo_q;
      tbl_wdata.time_ns = job_now_q;
    end
  end

  dlh_ram #(
    .Width($bits(entry_t)),
    .Depth(TableEntries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(cnt_q),
    .rdata_o(tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      cnt_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.clr_step) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.scan_chk) begin
      cnt_q <= cnt_q + 1'b1;
      if (ent_match && !hit_q) hit_q <= 1'b1;
      if (!tbl_rdata.valid && !free_q) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_chk) begin
      if (ent_match && !hit_q) begin
        hit_idx_q  <= cnt_q;
        hit_time_q <= tbl_rdata.time_ns;
      end
      if (!tbl_rdata.valid && !free_q) free_idx_q <= cnt_q;
    end
    if (cmd_i.decide) begin
      delta_q <= job_now_q - hit_time_q;
    end
  end

  // bucket search, one shift a cycle
  logic [63:0]   ld_q;
  logic [BW-1:0] li_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.log_init) begin
      ld_q <= {1'b0, delta_q[63:1]};
      li_q <= '0;
    end else if (cmd_i.log_step) begin
      ld_q <= {1'b0, ld_q[63:1]};
      li_q <= li_q + 1'b1;
    end
  end

  // histogram
  logic [HistogramBuckets-1:0] hv_q;
  logic [IW-1:0]               ridx_ext;
  logic [BW-1:0]               h_raddr, hsel_q;
  logic                        rd_ok, rd_ok_q;
  logic [63:0]                 h_rdata, h_base, h_inc;

  assign ridx_ext = IW'(ridx_q);
  assign rd_ok    = 32'(ridx_q) < HistogramBuckets;
  assign h_raddr  = cmd_i.hist_rd_log ? li_q : ridx_ext[BW-1:0];
  assign h_base   = (rd_ok_q && hv_q[hsel_q]) ? h_rdata : 64'd0;
  assign h_inc    = h_base + 64'd1;

  dlh_ram #(
    .Width(64),
    .Depth(HistogramBuckets)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (cmd_i.hist_inc),
    .waddr_i(hsel_q),
    .wdata_i(h_inc),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  always_ff @(posedge clk_i) begin
    hsel_q  <= h_raddr;
    rd_ok_q <= cmd_i.hist_rd_log || rd_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= '0;
    end else if (cmd_i.hist_inc) begin
      hv_q[hsel_q] <= 1'b1;
    end
  end

  // result register payload
  out_word_t out_word_d;

  always_comb begin
    out_word_d           = '0;
    out_word_d.outcome   = cmd_i.out_code;
    out_word_d.over_ipv6 = job_over6_q;
    if (cmd_i.out_code == OUT_COUNTED) begin
      out_word_d.bucket       = BKT_W'(hsel_q);
      out_word_d.bucket_count = h_inc;
    end else if (cmd_i.out_code == OUT_READ) begin
      out_word_d.bucket       = ridx_q;
      out_word_d.bucket_count = h_base;
      out_word_d.over_ipv6    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_word_o <= out_word_d;
    end
  end

  assign status_o.op       = in_word_i.operation;
  assign status_o.last     = in_word_i.frame_end;
  assign status_o.dns_ok   = dns_ok;
  assign status_o.job_resp = job_resp_q;
  assign status_o.cnt_last = (cnt_q == TW'(TableEntries - 1));
  assign status_o.hit      = hit_q;
  assign status_o.free     = free_q;
  assign status_o.in_limit = (delta_q <= max_rtt_q);
  assign status_o.log_done = (ld_q == 64'd0) || (li_q == BW'(HistogramBuckets - 1));

endmodule

`default_nettype wire

// ===== sv/dlh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlh_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire dlh_pkg::dlh_status_t status_i,
  output dlh_pkg::dlh_cmd_t         cmd_o
);
  import dlh_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ND    = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCK   = 4'd4;
  localparam logic [3:0] S_DEC   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_LOG   = 4'd7;
  localparam logic [3:0] S_HRD   = 4'd8;
  localparam logic [3:0] S_HWT   = 4'd9;
  localparam logic [3:0] S_RRD   = 4'd10;
  localparam logic [3:0] S_RWT   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (status_i.op) begin
            cmd_o.read_latch = 1'b1;
            state_d = S_RRD;
          end else begin
            cmd_o.parse_en = 1'b1;
            if (status_i.last) begin
              cmd_o.latch_job = 1'b1;
              if (status_i.dns_ok) begin
                cmd_o.scan_start = 1'b1;
                state_d = S_SRD;
              end else begin
                state_d = S_ND;
              end
            end
          end
        end
      end
      S_ND: begin
        cmd_o.out_ld   = 1'b1;
        cmd_o.out_code = OUT_NOT_DNS;
        state_d = S_IDLE;
      end
      S_SRD: state_d = S_SCK;
      S_SCK: begin
        cmd_o.scan_chk = 1'b1;
        state_d = status_i.cnt_last ? S_DEC : S_SRD;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        if (!status_i.job_resp) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_code = (status_i.hit || status_i.free) ? OUT_STORED : OUT_DROPPED;
          state_d = S_IDLE;
        end else if (!status_i.hit) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_code = OUT_UNMATCHED;
          state_d = S_IDLE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (status_i.in_limit) begin
          cmd_o.log_init = 1'b1;
          state_d = S_LOG;
        end else begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_code = OUT_OVER;
          state_d = S_IDLE;
        end
      end
      S_LOG: begin
        if (status_i.log_done) begin
          state_d = S_HRD;
        end else begin
          cmd_o.log_step = 1'b1;
        end
      end
      S_HRD: begin
        cmd_o.hist_rd_log = 1'b1;
        state_d = S_HWT;
      end
      S_HWT: begin
        cmd_o.hist_inc = 1'b1;
        cmd_o.out_ld   = 1'b1;
        cmd_o.out_code = OUT_COUNTED;
        state_d = S_IDLE;
      end
      S_RRD: state_d = S_RWT;
      S_RWT: begin
        cmd_o.out_ld   = 1'b1;
        cmd_o.out_code = OUT_READ;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_ld) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dns_latency_histogram_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake             | content
// ---------+-----------+-----------------------+-------------------------------------
// in       | in        | in_valid_i/in_stall_o | in_word_i: frame byte or bucket read
// out      | out       | out_valid_o/out_stall_i| out_word_o: one result word
// cfg      | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// work: a non-final frame byte leaves the core idle and ready for the next word; a bucket read
// passes through S_RRD and S_RWT; a DNS frame end scans the whole key table, reading and then
// checking each entry (S_SRD, S_SCK), followed for a response within the limit by the bucket search
// reset: a clearing pass marks every table entry free before the first word is taken;
// the histogram is cleared at once by valid bits
// stalls: no word is taken while the controller is busy or a result waits in the output register

module dns_latency_histogram_core #(
  parameter int unsigned TableEntries     = 1024,
  parameter int unsigned HistogramBuckets = 30
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input words
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire dlh_pkg::in_word_t  in_word_i,
  // result words
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output dlh_pkg::out_word_t      out_word_o,
  // register writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);
  import dlh_pkg::*;

  dlh_cmd_t    cmd;
  dlh_status_t status;

  // registers are to be written by the user only while idle; the block itself leaves this unchecked, so always ready
  assign cfg_ready_o = 1'b1;

  dlh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // parser, key table, bucket search and histogram
  dlh_datapath #(
    .TableEntries    (TableEntries),
    .HistogramBuckets(HistogramBuckets)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire
